@@ sv/aph_pkg.sv @@
package aph_pkg;

    localparam int DELAY_DEPTH_DEF   = 128;
    localparam int FRAC_BITS_DEF     = 12;
    localparam int GAIN_BITS_DEF     = 9;
    localparam int FEEDBACK_GAIN_DEF = 256;

    localparam int SAMPLE_W = 32;
    localparam int IN_W     = 23;
    localparam int WET_W    = 26;
    localparam int HIST_W   = IN_W + WET_W;
    localparam int PHASE_W  = 20;
    localparam int COUNT_W  = 21;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
        logic                       signal_present;
    } aph_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic                       active;
    } aph_out_t;

    typedef struct packed {
        logic [9:0]  wet_gain;
        logic        stereo_mode;
        logic [18:0] delay_min;
        logic [18:0] delay_max;
        logic [15:0] sweep_step;
        logic [19:0] silence_limit;
    } aph_cfg_t;

    localparam aph_cfg_t CFG_RESET = '{
        wet_gain:      10'd0,
        stereo_mode:   1'b1,
        delay_min:     19'd87114,
        delay_max:     19'd265961,
        sweep_step:    16'd8,
        silence_limit: 20'd44100
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WET_GAIN      = 3'd0,
        REG_STEREO_MODE   = 3'd1,
        REG_DELAY_MIN     = 3'd2,
        REG_DELAY_MAX     = 3'd3,
        REG_SWEEP_STEP    = 3'd4,
        REG_SILENCE_LIMIT = 3'd5
    } aph_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COUNT,
        S_MUL,
        S_SUM,
        S_FILT,
        S_YDIV,
        S_OMUL,
        S_FIN,
        S_PASS
    } aph_state_t;

    typedef struct packed {
        logic idle;
        logic rd_en;
        logic mul;
        logic sum;
        logic filt;
        logic ydiv;
        logic omul;
        logic wr_en;
        logic wr_right;
        logic clr_en;
        logic clr_right;
        logic load_proc;
        logic load_pass;
    } aph_ctl_t;

endpackage

@@ sv/aph_hist_mem.sv @@
module aph_hist_mem #(
    parameter int DELAY_DEPTH = aph_pkg::DELAY_DEPTH_DEF,
    localparam int AW = $clog2(DELAY_DEPTH)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr1,
    input  logic [AW-1:0]              rd_addr2,
    output logic [aph_pkg::HIST_W-1:0] rd_data1,
    output logic [aph_pkg::HIST_W-1:0] rd_data2,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [aph_pkg::HIST_W-1:0] wr_data,
    input  logic                       clr_en,
    input  logic [AW-1:0]              clr_base,
    input  logic [AW:0]                clr_count
);

    logic [aph_pkg::HIST_W-1:0] mem [DELAY_DEPTH];
    logic [aph_pkg::HIST_W-1:0] rd1_reg;
    logic [aph_pkg::HIST_W-1:0] rd2_reg;
    logic                       vld1_reg;
    logic                       vld2_reg;
    logic [DELAY_DEPTH-1:0]     valid_reg;
    logic [DELAY_DEPTH-1:0]     valid_next;

    // entries from base+1 up to base+count are zeroed by dropping their valid bit
    always_comb
    begin
        logic [AW-1:0] off;
        valid_next = valid_reg;
        for (int i = 0; i < DELAY_DEPTH; i++)
        begin
            off = AW'(i) - clr_base - AW'(1);
            if (clr_en && ({1'b0, off} < clr_count))
            begin
                valid_next[i] = 1'b0;
            end
        end
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd1_reg  <= mem[rd_addr1];
            rd2_reg  <= mem[rd_addr2];
            vld1_reg <= valid_reg[rd_addr1];
            vld2_reg <= valid_reg[rd_addr2];
        end
    end

    assign rd_data1 = vld1_reg ? rd1_reg : '0;
    assign rd_data2 = vld2_reg ? rd2_reg : '0;

endmodule

@@ sv/aph_interp.sv @@
module aph_interp #(
    parameter int W         = aph_pkg::IN_W,
    parameter int FRAC_BITS = aph_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 en_mul,
    input  logic                 en_sum,
    input  logic signed [W-1:0]  v1,
    input  logic signed [W-1:0]  v2,
    input  logic [FRAC_BITS-1:0] frac,
    output logic signed [W:0]    result
);

    localparam int PW = W + FRAC_BITS + 2;
    localparam logic [PW-1:0] RND = PW'((1 << FRAC_BITS) - 1);

    logic signed [W:0]    diff;
    logic [FRAC_BITS-1:0] t;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] prod_reg;
    logic signed [W-1:0]  v1_reg;
    logic signed [PW-1:0] rounded;
    logic signed [PW-1:0] quot;
    logic signed [W:0]    result_next;
    logic signed [W:0]    result_reg;

    assign t    = ~frac;
    assign diff = (W+1)'(v2) - (W+1)'(v1);
    assign prod = PW'(diff) * PW'($signed({1'b0, t}));

    // toward-zero division by the fraction scale
    assign rounded     = prod_reg + $signed(prod_reg[PW-1] ? RND : '0);
    assign quot        = rounded >>> FRAC_BITS;
    assign result_next = (W+1)'(v1_reg) + (W+1)'(quot);

    always_ff @(posedge clk)
    begin
        if (en_mul)
        begin
            prod_reg <= prod;
            v1_reg   <= v1;
        end
        if (en_sum)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

@@ sv/aph_chan.sv @@
module aph_chan #(
    parameter int FRAC_BITS     = aph_pkg::FRAC_BITS_DEF,
    parameter int GAIN_BITS     = aph_pkg::GAIN_BITS_DEF,
    parameter int FEEDBACK_GAIN = aph_pkg::FEEDBACK_GAIN_DEF
) (
    input  logic                                clk,
    input  aph_pkg::aph_ctl_t                   ctl,
    input  logic signed [aph_pkg::SAMPLE_W-1:0] sample,
    input  logic [FRAC_BITS-1:0]                frac,
    input  logic [aph_pkg::HIST_W-1:0]          rd1,
    input  logic [aph_pkg::HIST_W-1:0]          rd2,
    input  logic [9:0]                          wet_gain,
    output logic [aph_pkg::SAMPLE_W-1:0]        out_val,
    output logic [aph_pkg::HIST_W-1:0]          hist_word
);

    localparam int SW = aph_pkg::SAMPLE_W;
    localparam int XW = SW - GAIN_BITS;
    localparam int IW = aph_pkg::IN_W;
    localparam int YW = aph_pkg::WET_W;
    localparam logic [SW-1:0] GRND = SW'((1 << GAIN_BITS) - 1);

    logic signed [SW-1:0] xs;
    logic signed [SW-1:0] x_wide;
    logic signed [XW-1:0] x_reg;
    logic signed [IW:0]   xd;
    logic signed [YW:0]   yd;
    logic signed [SW-1:0] d;
    logic signed [SW-1:0] s_next;
    logic signed [SW-1:0] s_reg;
    logic signed [SW-1:0] s_rnd;
    logic signed [SW-1:0] y_wide;
    logic signed [XW-1:0] y_reg;
    logic signed [SW-1:0] gprod;
    logic [SW-1:0]        o_next;
    logic [SW-1:0]        o_reg;

    assign xs     = sample + $signed(sample[SW-1] ? GRND : '0);
    assign x_wide = xs >>> GAIN_BITS;

    aph_interp #(
        .W         (IW),
        .FRAC_BITS (FRAC_BITS)
    ) u_in_interp (
        .clk    (clk),
        .en_mul (ctl.mul),
        .en_sum (ctl.sum),
        .v1     (rd1[IW-1:0]),
        .v2     (rd2[IW-1:0]),
        .frac   (frac),
        .result (xd)
    );

    aph_interp #(
        .W         (YW),
        .FRAC_BITS (FRAC_BITS)
    ) u_wet_interp (
        .clk    (clk),
        .en_mul (ctl.mul),
        .en_sum (ctl.sum),
        .v1     (rd1[IW +: YW]),
        .v2     (rd2[IW +: YW]),
        .frac   (frac),
        .result (yd)
    );

    // allpass sum, wraps at 32 bits
    assign d      = SW'(yd) - SW'(x_reg);
    assign s_next = d * SW'(FEEDBACK_GAIN) + (SW'(xd) <<< GAIN_BITS);

    assign s_rnd  = s_reg + $signed(s_reg[SW-1] ? GRND : '0);
    assign y_wide = s_rnd >>> GAIN_BITS;

    assign gprod  = SW'($signed({1'b0, wet_gain})) * SW'(y_reg);
    assign o_next = (SW'(x_reg) << GAIN_BITS) + gprod;

    always_ff @(posedge clk)
    begin
        if (ctl.mul)
        begin
            x_reg <= XW'(x_wide);
        end
        if (ctl.filt)
        begin
            s_reg <= s_next;
        end
        if (ctl.ydiv)
        begin
            y_reg <= XW'(y_wide);
        end
        if (ctl.omul)
        begin
            o_reg <= o_next;
        end
    end

    assign out_val   = o_reg;
    assign hist_word = {YW'(y_reg), IW'(x_reg)};

endmodule

@@ sv/aph_ctrl.sv @@
module aph_ctrl #(
    parameter int DELAY_DEPTH = aph_pkg::DELAY_DEPTH_DEF,
    parameter int FRAC_BITS   = aph_pkg::FRAC_BITS_DEF,
    localparam int AW = $clog2(DELAY_DEPTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  aph_pkg::aph_cfg_t    cfg,
    input  logic                 in_fire,
    input  logic                 signal_present,
    input  logic                 out_free,
    output aph_pkg::aph_ctl_t    ctl,
    output logic [AW-1:0]        rd_addr1,
    output logic [AW-1:0]        rd_addr2,
    output logic [AW-1:0]        wr_addr,
    output logic [AW-1:0]        clr_base,
    output logic [AW:0]          clr_count,
    output logic [FRAC_BITS-1:0] frac
);

    localparam int PW = aph_pkg::PHASE_W;
    localparam int CW = aph_pkg::COUNT_W;

    aph_pkg::aph_state_t state_reg;
    aph_pkg::aph_state_t state_next;
    logic [AW-1:0]       ptr_reg;
    logic [PW-1:0]       phase_reg;
    logic [PW-1:0]       phase_sweep;
    logic                down_reg;
    logic                down_sweep;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                bypass;
    logic                silenced;
    logic [PW+AW-1:0]    k_wide;
    logic [AW-1:0]       k;
    logic [PW-1:0]       min_ext;
    logic [PW-1:0]       max_ext;
    logic [PW-1:0]       step_ext;

    assign bypass = (cfg.wet_gain == '0);

    always_comb
    begin
        if (signal_present)
        begin
            count_next = '0;
        end
        else if (count_reg != aph_pkg::COUNT_MAX)
        begin
            count_next = count_reg + CW'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    assign silenced  = (count_next >= CW'(cfg.silence_limit));
    assign clr_count = (count_next >= CW'(DELAY_DEPTH)) ? (AW+1)'(DELAY_DEPTH)
                                                         : count_next[AW:0];
    assign clr_base  = ptr_reg;

    // delayed read: k-th newest and the one after it
    assign k_wide   = {{AW{1'b0}}, phase_reg} >> FRAC_BITS;
    assign k        = k_wide[AW-1:0];
    assign rd_addr1 = ptr_reg - k;
    assign rd_addr2 = ptr_reg - k + AW'(1);
    assign wr_addr  = ptr_reg + AW'(1);
    assign frac     = phase_reg[FRAC_BITS-1:0];

    assign min_ext  = PW'(cfg.delay_min);
    assign max_ext  = PW'(cfg.delay_max);
    assign step_ext = PW'(cfg.sweep_step);

    // triangle sweep
    always_comb
    begin
        phase_sweep = phase_reg;
        down_sweep  = down_reg;
        priority if (phase_reg > max_ext)
        begin
            phase_sweep = max_ext;
            down_sweep  = 1'b1;
        end
        else if (phase_reg < min_ext)
        begin
            phase_sweep = min_ext;
            down_sweep  = 1'b0;
        end
        else if (down_reg)
        begin
            if (step_ext > phase_reg)
            begin
                phase_sweep = '0;
                down_sweep  = 1'b0;
            end
            else
            begin
                phase_sweep = phase_reg - step_ext;
            end
        end
        else
        begin
            phase_sweep = phase_reg + step_ext;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            aph_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = aph_pkg::S_COUNT;
                end
            end
            aph_pkg::S_COUNT:
            begin
                if (bypass || silenced)
                begin
                    state_next = aph_pkg::S_PASS;
                end
                else
                begin
                    state_next = aph_pkg::S_MUL;
                end
            end
            aph_pkg::S_MUL:  state_next = aph_pkg::S_SUM;
            aph_pkg::S_SUM:  state_next = aph_pkg::S_FILT;
            aph_pkg::S_FILT: state_next = aph_pkg::S_YDIV;
            aph_pkg::S_YDIV: state_next = aph_pkg::S_OMUL;
            aph_pkg::S_OMUL: state_next = aph_pkg::S_FIN;
            aph_pkg::S_FIN,
            aph_pkg::S_PASS:
            begin
                if (out_free)
                begin
                    state_next = aph_pkg::S_IDLE;
                end
            end
            default: state_next = aph_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl           = '0;
        ctl.idle      = (state_reg == aph_pkg::S_IDLE);
        ctl.rd_en     = (state_reg == aph_pkg::S_COUNT);
        ctl.mul       = (state_reg == aph_pkg::S_MUL);
        ctl.sum       = (state_reg == aph_pkg::S_SUM);
        ctl.filt      = (state_reg == aph_pkg::S_FILT);
        ctl.ydiv      = (state_reg == aph_pkg::S_YDIV);
        ctl.omul      = (state_reg == aph_pkg::S_OMUL);
        ctl.wr_en     = (state_reg == aph_pkg::S_FIN) && out_free;
        ctl.wr_right  = ctl.wr_en && cfg.stereo_mode;
        ctl.clr_en    = (state_reg == aph_pkg::S_COUNT) && !bypass && silenced;
        ctl.clr_right = ctl.clr_en && cfg.stereo_mode;
        ctl.load_proc = ctl.wr_en;
        ctl.load_pass = (state_reg == aph_pkg::S_PASS) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aph_pkg::S_IDLE;
            ptr_reg   <= '0;
            phase_reg <= PW'(aph_pkg::CFG_RESET.delay_min);
            down_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == aph_pkg::S_COUNT) && !bypass)
            begin
                count_reg <= count_next;
            end
            if (ctl.clr_en)
            begin
                ptr_reg   <= ptr_reg + clr_count[AW-1:0];
                phase_reg <= min_ext;
            end
            else if (ctl.wr_en)
            begin
                ptr_reg   <= wr_addr;
                phase_reg <= phase_sweep;
                down_reg  <= down_sweep;
            end
        end
    end

endmodule

@@ sv/audio_phaser_effect.sv @@
// Stereo phaser: each request carries one audio frame and yields one result
// frame. Each channel reads its input and filtered histories at a fractional
// delay, runs a first-order allpass with feedback one half and mixes the wet
// signal in by wet_gain over the dry sample; the delay sweeps as a triangle
// between delay_min and delay_max. A processed frame goes through the fixed
// sequence of history read, interpolation multiply, interpolation sum, allpass
// sum, wet scaling, gain multiply and write-back on one channel memory per side;
// with stereo_mode off the right output is the dry sample. Bypass frames
// (wet_gain zero) and frames once the silence limit is reached pass through.
// The result register lets the next request in while a result waits; a new
// result waits only while the previous one is still held. Histories come out
// of reset cleared through per-entry valid bits, so no clearing pass is run.
// Configuration writes are taken at any time but must only be issued while idle.
module audio_phaser_effect #(
    parameter int DELAY_DEPTH   = aph_pkg::DELAY_DEPTH_DEF,
    parameter int FRAC_BITS     = aph_pkg::FRAC_BITS_DEF,
    parameter int GAIN_BITS     = aph_pkg::GAIN_BITS_DEF,
    parameter int FEEDBACK_GAIN = aph_pkg::FEEDBACK_GAIN_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  aph_pkg::aph_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output aph_pkg::aph_out_t               out_data,
    input  logic                            cfg_wr_en,
    input  logic [aph_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [aph_pkg::CFG_W-1:0]       cfg_data
);

    localparam int AW = $clog2(DELAY_DEPTH);

    aph_pkg::aph_cfg_t          cfg_reg;
    aph_pkg::aph_in_t           in_reg;
    aph_pkg::aph_out_t          out_reg;
    aph_pkg::aph_out_t          out_next;
    logic                       out_valid_reg;
    logic                       out_free;
    logic                       in_fire;
    aph_pkg::aph_ctl_t          ctl;
    logic [AW-1:0]              rd_addr1;
    logic [AW-1:0]              rd_addr2;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              clr_base;
    logic [AW:0]                clr_count;
    logic [FRAC_BITS-1:0]       frac;
    logic [aph_pkg::HIST_W-1:0] l_rd1;
    logic [aph_pkg::HIST_W-1:0] l_rd2;
    logic [aph_pkg::HIST_W-1:0] r_rd1;
    logic [aph_pkg::HIST_W-1:0] r_rd2;
    logic [aph_pkg::HIST_W-1:0] l_word;
    logic [aph_pkg::HIST_W-1:0] r_word;
    logic [aph_pkg::SAMPLE_W-1:0] l_val;
    logic [aph_pkg::SAMPLE_W-1:0] r_val;

    assign in_ready = ctl.idle;
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= aph_pkg::CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (aph_pkg::aph_reg_t'(cfg_index))
                aph_pkg::REG_WET_GAIN:      cfg_reg.wet_gain      <= cfg_data[9:0];
                aph_pkg::REG_STEREO_MODE:   cfg_reg.stereo_mode   <= cfg_data[0];
                aph_pkg::REG_DELAY_MIN:     cfg_reg.delay_min     <= cfg_data[18:0];
                aph_pkg::REG_DELAY_MAX:     cfg_reg.delay_max     <= cfg_data[18:0];
                aph_pkg::REG_SWEEP_STEP:    cfg_reg.sweep_step    <= cfg_data[15:0];
                aph_pkg::REG_SILENCE_LIMIT: cfg_reg.silence_limit <= cfg_data[19:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_reg <= in_data;
        end
    end

    aph_ctrl #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_fire        (in_fire),
        .signal_present (in_reg.signal_present),
        .out_free       (out_free),
        .ctl            (ctl),
        .rd_addr1       (rd_addr1),
        .rd_addr2       (rd_addr2),
        .wr_addr        (wr_addr),
        .clr_base       (clr_base),
        .clr_count      (clr_count),
        .frac           (frac)
    );

    aph_hist_mem #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_left_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (ctl.rd_en),
        .rd_addr1  (rd_addr1),
        .rd_addr2  (rd_addr2),
        .rd_data1  (l_rd1),
        .rd_data2  (l_rd2),
        .wr_en     (ctl.wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (l_word),
        .clr_en    (ctl.clr_en),
        .clr_base  (clr_base),
        .clr_count (clr_count)
    );

    aph_hist_mem #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_right_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (ctl.rd_en),
        .rd_addr1  (rd_addr1),
        .rd_addr2  (rd_addr2),
        .rd_data1  (r_rd1),
        .rd_data2  (r_rd2),
        .wr_en     (ctl.wr_right),
        .wr_addr   (wr_addr),
        .wr_data   (r_word),
        .clr_en    (ctl.clr_right),
        .clr_base  (clr_base),
        .clr_count (clr_count)
    );

    aph_chan #(
        .FRAC_BITS     (FRAC_BITS),
        .GAIN_BITS     (GAIN_BITS),
        .FEEDBACK_GAIN (FEEDBACK_GAIN)
    ) u_left_chan (
        .clk       (clk),
        .ctl       (ctl),
        .sample    (in_reg.left_sample),
        .frac      (frac),
        .rd1       (l_rd1),
        .rd2       (l_rd2),
        .wet_gain  (cfg_reg.wet_gain),
        .out_val   (l_val),
        .hist_word (l_word)
    );

    aph_chan #(
        .FRAC_BITS     (FRAC_BITS),
        .GAIN_BITS     (GAIN_BITS),
        .FEEDBACK_GAIN (FEEDBACK_GAIN)
    ) u_right_chan (
        .clk       (clk),
        .ctl       (ctl),
        .sample    (in_reg.right_sample),
        .frac      (frac),
        .rd1       (r_rd1),
        .rd2       (r_rd2),
        .wet_gain  (cfg_reg.wet_gain),
        .out_val   (r_val),
        .hist_word (r_word)
    );

    always_comb
    begin
        out_next.left_out       = in_reg.left_sample;
        out_next.right_out      = in_reg.right_sample;
        out_next.active         = in_reg.signal_present;
        if (ctl.load_proc)
        begin
            out_next.left_out  = $signed(l_val);
            out_next.right_out = cfg_reg.stereo_mode ? $signed(r_val) : in_reg.right_sample;
            out_next.active    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.load_proc || ctl.load_pass)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_proc || ctl.load_pass)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.load_proc || ctl.load_pass) |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while held");

    a_read_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> ctl.rd_en)
        else $error("history read not issued after request");

    a_no_write_then_read: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rd_en |-> !$past(ctl.wr_en))
        else $error("history read directly behind write-back");

endmodule
